// ===== rtl/pcmu_pkg.sv =====
// Package for the Potts coupling momentum update core.
// Holds widths, codes, the item and configuration structs and the saturation helper.
// Has no dependencies; every file of the block imports it.
package pcmu_pkg;

    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 24;
    localparam int COUNT_W = 24;
    localparam int GAIN_W  = 16;
    localparam int MARG_W  = FRAC_W + 1;
    localparam int SUM_W   = 64;
    localparam int CUT_W   = DATA_W - 1;

    localparam int PROD_W  = 2 * MARG_W - FRAC_W;
    localparam int CORR_W  = DATA_W + 3;
    localparam int DIFF_W  = DATA_W + 2;
    localparam int DEL_W   = DIFF_W + 2;
    localparam int SQ_W    = 2 * DIFF_W - FRAC_W;
    localparam int RAD_W   = SUM_W + FRAC_W;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 2;
    localparam int CNT_W   = $clog2(SUM_W);

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = DATA_W;

    // magnitude of the -1e-5 clamp value in the data format, at least one LSB
    localparam longint CLAMP_RAW = ((64'd1 << FRAC_W) + 64'd50000) / 64'd100000;
    localparam longint CLAMP_MAG = (CLAMP_RAW == 0) ? 1 : CLAMP_RAW;

    localparam logic [GAIN_W-1:0] STEP_GAIN_RST = GAIN_W'(655);
    localparam logic [GAIN_W-1:0] MOM_GAIN_RST  = GAIN_W'(62259);

    typedef enum logic [1:0] {
        KIND_CC = 2'd0,
        KIND_CI = 2'd1,
        KIND_IC = 2'd2,
        KIND_II = 2'd3
    } kind_t;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOM_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_CC    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_CI    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_IC    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_II    = 3'd6;

    typedef logic [3:0][DATA_W-1:0] offset_set_t;

    typedef struct packed {
        logic [GAIN_W-1:0] step_gain;
        logic [GAIN_W-1:0] momentum_gain;
        logic [CUT_W-1:0]  corr_cutoff;
    } cfg_t;

    // classified element as it travels from the front queue to the engine
    typedef struct packed {
        logic                     ins_ins;
        logic                     last;
        logic signed [DATA_W-1:0] pair;
        logic signed [DATA_W-1:0] expd;
        logic signed [DATA_W-1:0] gauge;
        logic signed [DATA_W-1:0] offset;
        logic signed [DATA_W-1:0] coup;
        logic signed [DATA_W-1:0] mom;
        logic [MARG_W-1:0]        m1;
        logic [MARG_W-1:0]        m2;
    } item_t;

    function automatic logic [DATA_W-1:0] sat_data(input logic signed [DEL_W-1:0] v);
        logic signed [DEL_W-1:0] hi;
        logic signed [DEL_W-1:0] lo;
        hi = $signed({{(DEL_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}});
        lo = ~hi;
        if (v > hi)
            sat_data = hi[DATA_W-1:0];
        else if (v < lo)
            sat_data = lo[DATA_W-1:0];
        else
            sat_data = v[DATA_W-1:0];
    endfunction

endpackage

// ===== rtl/pcmu_front.sv =====
// Front end: accepts elements, classifies them by kind and queues them.
// Depends on pcmu_pkg; feeds pcmu_engine through a two-entry queue.
module pcmu_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [1:0]                   opcode,
    input  logic signed [pcmu_pkg::DATA_W-1:0] pair_freq,
    input  logic signed [pcmu_pkg::DATA_W-1:0] pair_expected,
    input  logic [pcmu_pkg::MARG_W-1:0]  first_marginal,
    input  logic [pcmu_pkg::MARG_W-1:0]  second_marginal,
    input  logic signed [pcmu_pkg::DATA_W-1:0] gauge_term,
    input  logic signed [pcmu_pkg::DATA_W-1:0] coupling,
    input  logic signed [pcmu_pkg::DATA_W-1:0] momentum,
    input  logic                         last_element,
    input  pcmu_pkg::offset_set_t        offsets,
    output logic                         q_valid,
    output pcmu_pkg::item_t              q_item,
    input  logic                         q_pop
);
    import pcmu_pkg::*;

    item_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;
    item_t      new_item;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_pop && q_valid;

    always_comb
    begin
        new_item.ins_ins = (kind_t'(opcode) == KIND_II);
        new_item.last    = last_element;
        new_item.pair    = pair_freq;
        new_item.expd    = pair_expected;
        // mixed kinds take half the gauge term, rounded toward minus infinity
        new_item.gauge   = (kind_t'(opcode) == KIND_CC) ? gauge_term : (gauge_term >>> 1);
        new_item.offset  = offsets[opcode];
        new_item.coup    = coupling;
        new_item.mom     = momentum;
        new_item.m1      = first_marginal;
        new_item.m2      = second_marginal;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= new_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== rtl/pcmu_engine.sv =====
// Back end: carries out the coupling update, the square-sum tally and the
// end-of-sweep divide and root. Depends on pcmu_pkg; fed by pcmu_front.
module pcmu_engine (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pcmu_pkg::cfg_t               cfg,
    input  logic                         in_valid,
    input  pcmu_pkg::item_t              in_item,
    output logic                         in_pop,
    output logic                         empty,
    input  logic                         pop,
    output logic [pcmu_pkg::DATA_W-1:0]  new_coupling,
    output logic [pcmu_pkg::DATA_W-1:0]  new_momentum,
    output logic                         element_counted,
    output logic                         rms_valid,
    output logic [pcmu_pkg::CUT_W-1:0]   rms_diff
);
    import pcmu_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_PROD, S_DIFF, S_GAIN, S_SUM, S_DIV, S_SQRT
    } state_t;

    state_t                   state_reg;
    item_t                    cur_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic                     above_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic [DIFF_W+GAIN_W-1:0] pa_reg;
    logic [DATA_W+GAIN_W-1:0] pb_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic                     dneg_reg;
    logic                     mneg_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic [COUNT_W-1:0]       count_reg;
    logic [SUM_W-1:0]         quot_reg;
    logic [COUNT_W-1:0]       drem_reg;
    logic [COUNT_W-1:0]       divisor_reg;
    logic [RAD_W-1:0]         rad_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic [REM_W-1:0]         srem_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     out_valid_reg;
    logic [DATA_W-1:0]        coup_out_reg;
    logic [DATA_W-1:0]        mom_out_reg;
    logic                     counted_out_reg;
    logic                     rms_valid_reg;
    logic [CUT_W-1:0]         rms_reg;

    logic [2*MARG_W-1:0]       mprod;
    logic signed [CORR_W-1:0]  corr;
    logic [CORR_W-1:0]         corr_mag;
    logic                      above;
    logic signed [DIFF_W-1:0]  pe;
    logic signed [DIFF_W-1:0]  diff_c;
    logic [DIFF_W-1:0]         dmag;
    logic [DATA_W-1:0]         mmag;
    logic [2*DIFF_W-1:0]       sq_full;
    logic signed [DEL_W-1:0]   ta;
    logic signed [DEL_W-1:0]   tb;
    logic [DATA_W-1:0]         nm;
    logic signed [DEL_W-1:0]   csum;
    logic [DATA_W-1:0]         nc;
    logic [DATA_W-1:0]         nm_out;
    logic                      counted;
    logic [SUM_W:0]            sum_add;
    logic [SUM_W-1:0]          sum_fin;
    logic [COUNT_W-1:0]        count_fin;
    logic [COUNT_W:0]          dtrial;
    logic                      dge;
    logic [COUNT_W:0]          ddiff;
    logic [SUM_W-1:0]          quot_next;
    logic [REM_W-1:0]          srem_sh;
    logic [REM_W-1:0]          strial;
    logic                      sge;
    logic [ROOT_W-1:0]         root_next;
    logic [CUT_W-1:0]          rms_sat;

    assign in_pop          = (state_reg == S_IDLE) && in_valid && !out_valid_reg;
    assign empty           = !out_valid_reg;
    assign new_coupling    = coup_out_reg;
    assign new_momentum    = mom_out_reg;
    assign element_counted = counted_out_reg;
    assign rms_valid       = rms_valid_reg;
    assign rms_diff        = rms_reg;

    always_comb
    begin
        mprod    = {{MARG_W{1'b0}}, cur_reg.m1} * {{MARG_W{1'b0}}, cur_reg.m2};

        corr     = CORR_W'(cur_reg.pair) - $signed({{(CORR_W-PROD_W){1'b0}}, prod_reg})
                   - CORR_W'(cur_reg.offset);
        corr_mag = corr[CORR_W-1] ? CORR_W'(-corr) : CORR_W'(corr);
        above    = corr_mag > CORR_W'(cfg.corr_cutoff);
        pe       = DIFF_W'(cur_reg.pair) - DIFF_W'(cur_reg.expd);
        diff_c   = (cur_reg.ins_ins ? '0 : DIFF_W'(cur_reg.gauge)) + (above ? pe : '0);

        dmag     = diff_reg[DIFF_W-1] ? DIFF_W'(-diff_reg) : DIFF_W'(diff_reg);
        mmag     = cur_reg.mom[DATA_W-1] ? DATA_W'(-cur_reg.mom) : DATA_W'(cur_reg.mom);
        sq_full  = {{DIFF_W{1'b0}}, dmag} * {{DIFF_W{1'b0}}, dmag};

        // truncate each gain product toward zero, then restore the sign
        ta = $signed(DEL_W'(pa_reg[DIFF_W+GAIN_W-1:GAIN_W]));
        tb = $signed(DEL_W'(pb_reg[DATA_W+GAIN_W-1:GAIN_W]));
        if (dneg_reg)
            ta = -ta;
        if (mneg_reg)
            tb = -tb;
        nm   = sat_data(ta + tb);
        csum = DEL_W'(cur_reg.coup) + DEL_W'($signed(nm));
        if (!cur_reg.ins_ins)
            nc = sat_data(csum);
        else if (!above_reg)
            nc = cur_reg.coup;
        else if (!csum[DEL_W-1])
            nc = DATA_W'(0) - DATA_W'(CLAMP_MAG);
        else
            nc = sat_data(csum);
        counted = !cur_reg.ins_ins || above_reg;
        nm_out  = counted ? nm : cur_reg.mom;

        sum_add   = {1'b0, sum_reg} + (SUM_W + 1)'(sq_reg);
        sum_fin   = !counted ? sum_reg : (sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0]);
        count_fin = (counted && (count_reg != '1)) ? count_reg + COUNT_W'(1) : count_reg;

        dtrial    = {drem_reg, quot_reg[SUM_W-1]};
        dge       = dtrial >= {1'b0, divisor_reg};
        ddiff     = dtrial - {1'b0, divisor_reg};
        quot_next = {quot_reg[SUM_W-2:0], dge};

        srem_sh   = {srem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        strial    = {root_reg, 2'b01};
        sge       = srem_sh >= strial;
        root_next = {root_reg[ROOT_W-2:0], sge};
        rms_sat   = (root_next > ROOT_W'({CUT_W{1'b1}})) ? '1 : root_next[CUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            sum_reg         <= '0;
            count_reg       <= '0;
            cur_reg         <= '0;
            prod_reg        <= '0;
            above_reg       <= 1'b0;
            diff_reg        <= '0;
            pa_reg          <= '0;
            pb_reg          <= '0;
            sq_reg          <= '0;
            dneg_reg        <= 1'b0;
            mneg_reg        <= 1'b0;
            quot_reg        <= '0;
            drem_reg        <= '0;
            divisor_reg     <= '0;
            rad_reg         <= '0;
            root_reg        <= '0;
            srem_reg        <= '0;
            cnt_reg         <= '0;
            coup_out_reg    <= '0;
            mom_out_reg     <= '0;
            counted_out_reg <= 1'b0;
            rms_valid_reg   <= 1'b0;
            rms_reg         <= '0;
        end
        else
        begin
            if (pop && out_valid_reg)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_pop)
                    begin
                        cur_reg   <= in_item;
                        state_reg <= S_PROD;
                    end
                end
                S_PROD:
                begin
                    prod_reg  <= mprod[2*MARG_W-1:FRAC_W];
                    state_reg <= S_DIFF;
                end
                S_DIFF:
                begin
                    above_reg <= above;
                    diff_reg  <= diff_c;
                    state_reg <= S_GAIN;
                end
                S_GAIN:
                begin
                    pa_reg    <= {{GAIN_W{1'b0}}, dmag} * {{DIFF_W{1'b0}}, cfg.step_gain};
                    pb_reg    <= {{GAIN_W{1'b0}}, mmag} * {{DATA_W{1'b0}}, cfg.momentum_gain};
                    sq_reg    <= sq_full[2*DIFF_W-1:FRAC_W];
                    dneg_reg  <= diff_reg[DIFF_W-1];
                    mneg_reg  <= cur_reg.mom[DATA_W-1];
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    coup_out_reg    <= nc;
                    mom_out_reg     <= nm_out;
                    counted_out_reg <= counted;
                    rms_valid_reg   <= cur_reg.last;
                    rms_reg         <= '0;
                    if (cur_reg.last)
                    begin
                        sum_reg   <= '0;
                        count_reg <= '0;
                    end
                    else
                    begin
                        sum_reg   <= sum_fin;
                        count_reg <= count_fin;
                    end
                    if (cur_reg.last && (count_fin != '0))
                    begin
                        quot_reg    <= sum_fin;
                        divisor_reg <= count_fin;
                        drem_reg    <= '0;
                        cnt_reg     <= CNT_W'(SUM_W - 1);
                        state_reg   <= S_DIV;
                    end
                    else
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_DIV:
                begin
                    // one quotient bit a cycle, restoring
                    quot_reg <= quot_next;
                    drem_reg <= dge ? ddiff[COUNT_W-1:0] : dtrial[COUNT_W-1:0];
                    cnt_reg  <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == '0)
                    begin
                        rad_reg   <= {quot_next, {FRAC_W{1'b0}}};
                        root_reg  <= '0;
                        srem_reg  <= '0;
                        cnt_reg   <= CNT_W'(ROOT_W - 1);
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    // one root bit a cycle from two radicand bits
                    root_reg <= root_next;
                    srem_reg <= sge ? (srem_sh - strial) : srem_sh;
                    rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
                    cnt_reg  <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == '0)
                    begin
                        rms_reg       <= rms_sat;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_no_result_during_root: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV || state_reg == S_SQRT) |-> !out_valid_reg)
        else $error("result shown while the root is still running");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_pop |-> (state_reg == S_IDLE && !out_valid_reg))
        else $error("element taken while the engine is busy");

    a_rms_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rms_valid_reg) |-> (rms_reg == '0))
        else $error("rms reported on an element that is not last");

    a_sweep_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM && cur_reg.last) |=> (count_reg == '0 && sum_reg == '0))
        else $error("tally not cleared after the last element");

endmodule

// ===== rtl/potts_coupling_momentum_update_core.sv =====
// Top level of the Potts coupling momentum update core.
// Holds the configuration registers and joins pcmu_front to pcmu_engine; uses pcmu_pkg.
//
// Each element passes through a two-entry front queue and then through the
// engine steps in order (take, marginal product, correlation and diff, gain
// and square products, sums and saturation); the result register is loaded in
// the last step. The engine takes the next element only once the result
// register is free, so it works on one element at a time and waits for its
// result to leave before taking another. An element marked last with a
// non-empty tally also runs the bit-serial divide and the bit-serial square
// root before its result appears. While a result waits to be popped the engine
// holds, and the input side keeps taking elements until the queue holds two.
module potts_coupling_momentum_update_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [pcmu_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [pcmu_pkg::CFG_DAT_W-1:0]      wr_data,
    input  logic                                push,
    output logic                                full,
    input  logic [1:0]                          opcode,
    input  logic signed [pcmu_pkg::DATA_W-1:0]  pair_freq,
    input  logic signed [pcmu_pkg::DATA_W-1:0]  pair_expected,
    input  logic [pcmu_pkg::MARG_W-1:0]         first_marginal,
    input  logic [pcmu_pkg::MARG_W-1:0]         second_marginal,
    input  logic signed [pcmu_pkg::DATA_W-1:0]  gauge_term,
    input  logic signed [pcmu_pkg::DATA_W-1:0]  coupling,
    input  logic signed [pcmu_pkg::DATA_W-1:0]  momentum,
    input  logic                                last_element,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [pcmu_pkg::DATA_W-1:0]  new_coupling,
    output logic signed [pcmu_pkg::DATA_W-1:0]  new_momentum,
    output logic                                element_counted,
    output logic                                rms_valid,
    output logic [pcmu_pkg::CUT_W-1:0]          rms_diff
);
    import pcmu_pkg::*;

    logic [GAIN_W-1:0] step_gain_reg;
    logic [GAIN_W-1:0] momentum_gain_reg;
    logic [CUT_W-1:0]  corr_cutoff_reg;
    offset_set_t       offset_reg;
    cfg_t              cfg;
    logic              q_valid;
    item_t             q_item;
    logic              q_pop;
    logic [DATA_W-1:0] coup_out;
    logic [DATA_W-1:0] mom_out;

    assign cfg.step_gain     = step_gain_reg;
    assign cfg.momentum_gain = momentum_gain_reg;
    assign cfg.corr_cutoff   = corr_cutoff_reg;
    assign new_coupling      = $signed(coup_out);
    assign new_momentum      = $signed(mom_out);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_gain_reg     <= STEP_GAIN_RST;
            momentum_gain_reg <= MOM_GAIN_RST;
            corr_cutoff_reg   <= '0;
            offset_reg        <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_STEP_GAIN: step_gain_reg      <= wr_data[GAIN_W-1:0];
                REG_MOM_GAIN:  momentum_gain_reg  <= wr_data[GAIN_W-1:0];
                REG_CUTOFF:    corr_cutoff_reg    <= wr_data[CUT_W-1:0];
                REG_OFF_CC:    offset_reg[KIND_CC] <= wr_data[DATA_W-1:0];
                REG_OFF_CI:    offset_reg[KIND_CI] <= wr_data[DATA_W-1:0];
                REG_OFF_IC:    offset_reg[KIND_IC] <= wr_data[DATA_W-1:0];
                REG_OFF_II:    offset_reg[KIND_II] <= wr_data[DATA_W-1:0];
                default:       offset_reg         <= offset_reg;
            endcase
        end
    end

    pcmu_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .opcode          (opcode),
        .pair_freq       (pair_freq),
        .pair_expected   (pair_expected),
        .first_marginal  (first_marginal),
        .second_marginal (second_marginal),
        .gauge_term      (gauge_term),
        .coupling        (coupling),
        .momentum        (momentum),
        .last_element    (last_element),
        .offsets         (offset_reg),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .q_pop           (q_pop)
    );

    pcmu_engine u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .in_valid        (q_valid),
        .in_item         (q_item),
        .in_pop          (q_pop),
        .empty           (empty),
        .pop             (pop),
        .new_coupling    (coup_out),
        .new_momentum    (mom_out),
        .element_counted (element_counted),
        .rms_valid       (rms_valid),
        .rms_diff        (rms_diff)
    );

endmodule

// ===== tb/tb_potts_coupling_momentum_update_core.sv =====
// Testbench for the Potts coupling momentum update core.
// Drives element transactions and register writes, predicts each result and checks it;
// depends on pcmu_pkg and potts_coupling_momentum_update_core.
module tb_potts_coupling_momentum_update_core;
    timeunit 1ns;
    timeprecision 1ps;
    import pcmu_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 130;

    typedef struct {
        kind_t                   kind;
        logic signed [DATA_W-1:0] pair;
        logic signed [DATA_W-1:0] expd;
        logic [MARG_W-1:0]       m1;
        logic [MARG_W-1:0]       m2;
        logic signed [DATA_W-1:0] gauge;
        logic signed [DATA_W-1:0] coup;
        logic signed [DATA_W-1:0] mom;
        logic                    last;
    } element_t;

    typedef struct {
        logic [DATA_W-1:0] coup;
        logic [DATA_W-1:0] mom;
        logic              counted;
        logic              rvalid;
        logic [CUT_W-1:0]  rms;
    } update_t;

    logic clk, rst_n, wr_en, push, pop, last_element;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [CFG_DAT_W-1:0] wr_data;
    logic [1:0] opcode;
    logic signed [DATA_W-1:0] pair_freq, pair_expected, gauge_term, coupling, momentum;
    logic [MARG_W-1:0] first_marginal, second_marginal;
    logic full, empty, element_counted, rms_valid;
    logic signed [DATA_W-1:0] new_coupling, new_momentum;
    logic [CUT_W-1:0] rms_diff;

    // predictor state and configuration
    longint unsigned step_gain_q, mom_gain_q, cutoff_q;
    longint          offset_q [4];
    longint unsigned square_total;
    longint unsigned tally;

    update_t expected_updates [$];
    int      errors;
    int      stall_cycles;
    bit      idle_on;

    potts_coupling_momentum_update_core uut (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint unsigned magn(longint v);
        return (v < 0) ? longint'(0) - v : v;
    endfunction

    function automatic longint apply_gain(longint v, longint unsigned g);
        longint unsigned m;
        m = (magn(v) * g) >> GAIN_W;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clip_data(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic update_t predict_update(element_t e);
        longint unsigned a, mean, cm;
        longint prod, corr, diff, pair, del, nc;
        logic [127:0] dm, sq, rad, cand;
        logic [63:0] root, c;
        bit above, counted;
        update_t r;
        a = e.m1;
        prod = longint'((a * longint'(e.m2)) >> FRAC_W);
        pair = e.pair;
        corr = pair - prod - offset_q[e.kind];
        above = magn(corr) > cutoff_q;
        diff = 0;
        counted = 1'b0;
        r.coup = e.coup;
        r.mom = e.mom;
        if (e.kind != KIND_II) begin
            diff = (e.kind == KIND_CC) ? longint'(e.gauge) : longint'(e.gauge >>> 1);
            if (above)
                diff += pair - longint'(e.expd);
            del = clip_data(apply_gain(diff, step_gain_q) + apply_gain(e.mom, mom_gain_q));
            r.mom = del[DATA_W-1:0];
            nc = clip_data(longint'(e.coup) + del);
            r.coup = nc[DATA_W-1:0];
            counted = 1'b1;
        end else if (above) begin
            cm = ((64'd1 << FRAC_W) + 64'd50000) / 64'd100000;
            if (cm == 0)
                cm = 1;
            diff = pair - longint'(e.expd);
            del = clip_data(apply_gain(diff, step_gain_q) + apply_gain(e.mom, mom_gain_q));
            r.mom = del[DATA_W-1:0];
            // clamp to a small negative value when the coupling would turn non-negative
            nc = (longint'(e.coup) + del >= 0) ? -longint'(cm)
                                               : clip_data(longint'(e.coup) + del);
            r.coup = nc[DATA_W-1:0];
            counted = 1'b1;
        end
        if (counted) begin
            dm = magn(diff);
            sq = (dm * dm) >> FRAC_W;
            if (sq[127:64] != 0)
                sq = {64'd0, 64'hFFFF_FFFF_FFFF_FFFF};
            square_total = (sq[63:0] > ~square_total) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                      : square_total + sq[63:0];
            if (tally < (64'd1 << COUNT_W) - 1)
                tally++;
        end
        r.counted = counted;
        r.rvalid = e.last;
        r.rms = '0;
        if (e.last) begin
            if (tally != 0) begin
                mean = square_total / tally;
                rad = {64'd0, mean} << FRAC_W;
                root = '0;
                for (int b = 63; b >= 0; b--) begin
                    c = root | (64'd1 << b);
                    cand = {64'd0, c} * {64'd0, c};
                    if (cand <= rad)
                        root = c;
                end
                r.rms = (root > 64'h7FFF_FFFF) ? {CUT_W{1'b1}} : root[CUT_W-1:0];
            end
            square_total = 0;
            tally = 0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0h, expected %0h at %0t", field, got, want, $realtime);
        errors++;
    endtask

    task automatic send_element(element_t e);
        if (idle_on && $urandom_range(0, 99) < 14) begin
            @(negedge clk);
            push = 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge clk);
        end
        @(negedge clk);
        opcode = e.kind;
        pair_freq = e.pair;
        pair_expected = e.expd;
        first_marginal = e.m1;
        second_marginal = e.m2;
        gauge_term = e.gauge;
        coupling = e.coup;
        momentum = e.mom;
        last_element = e.last;
        push = 1'b1;
        forever begin
            @(posedge clk);
            if (!full)
                break;
        end
        expected_updates.push_back(predict_update(e));
    endtask

    task automatic finish_burst();
        @(negedge clk);
        push = 1'b0;
    endtask

    task automatic wait_drained();
        wait (expected_updates.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        @(negedge clk);
        wr_en = 1'b1;
        wr_index = idx;
        wr_data = val;
        case (idx)
            REG_STEP_GAIN: step_gain_q = val[GAIN_W-1:0];
            REG_MOM_GAIN:  mom_gain_q = val[GAIN_W-1:0];
            REG_CUTOFF:    cutoff_q = val[CUT_W-1:0];
            REG_OFF_CC, REG_OFF_CI, REG_OFF_IC, REG_OFF_II:
                offset_q[idx - REG_OFF_CC] = longint'($signed(val));
            default: ;
        endcase
        @(negedge clk);
        wr_en = 1'b0;
    endtask

    task automatic write_all(logic [31:0] sg, logic [31:0] mg, logic [31:0] cut,
                             logic [31:0] o0, logic [31:0] o1, logic [31:0] o2,
                             logic [31:0] o3);
        write_reg(REG_STEP_GAIN, sg);
        write_reg(REG_MOM_GAIN, mg);
        write_reg(REG_CUTOFF, cut);
        write_reg(REG_OFF_CC, o0);
        write_reg(REG_OFF_CI, o1);
        write_reg(REG_OFF_IC, o2);
        write_reg(REG_OFF_II, o3);
    endtask

    function automatic element_t make_element(bit noisy, bit last);
        element_t e;
        e.kind = kind_t'($urandom_range(0, 3));
        e.last = last;
        if (noisy) begin
            e.pair = $urandom;
            e.expd = $urandom;
            e.m1 = MARG_W'($urandom);
            e.m2 = MARG_W'($urandom);
            e.gauge = $urandom;
            e.coup = $urandom;
            e.mom = $urandom;
        end else begin
            e.pair = $urandom_range(0, 1 << FRAC_W);
            e.expd = $urandom_range(0, 1 << FRAC_W);
            e.m1 = MARG_W'($urandom_range(0, 1 << FRAC_W));
            e.m2 = MARG_W'($urandom_range(0, 1 << FRAC_W));
            e.gauge = $signed($urandom_range(0, 1 << 23)) - (1 << 22);
            e.coup = -$signed($urandom_range(0, 1 << 25));
            e.mom = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
        end
        return e;
    endfunction

    function automatic element_t pick(kind_t k, logic [31:0] p, logic [31:0] x,
                                      logic [24:0] a, logic [24:0] b, logic [31:0] g,
                                      logic [31:0] cp, logic [31:0] m, logic l);
        element_t e;
        e.kind = k; e.pair = p; e.expd = x; e.m1 = a; e.m2 = b;
        e.gauge = g; e.coup = cp; e.mom = m; e.last = l;
        return e;
    endfunction

    task automatic test_directed();
        // empty sweep: insert-insert below the cutoff counts nothing
        send_element(pick(KIND_II, 0, 0, 0, 0, 0, 32'hFFFF_0000, 5, 1'b1));
        send_element(pick(KIND_CC, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
        send_element(pick(KIND_CI, 32'h8000_0000, 32'h7FFF_FFFF, 25'h1FF_FFFF, 25'h1FF_FFFF,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0));
        // odd negative gauge halves toward minus infinity
        send_element(pick(KIND_IC, 32'h0100_0000, 0, 25'h100_0000, 25'h100_0000, -3,
                          0, 0, 1'b0));
        send_element(pick(KIND_CI, 0, 0, 25'h100_0000, 25'h080_0000, -1, 0, 0, 1'b0));
        // insert-insert clamp when the coupling would go non-negative
        send_element(pick(KIND_II, 32'h0200_0000, 0, 0, 0, 0, -5, 32'h0100_0000, 1'b0));
        send_element(pick(KIND_II, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0,
                          32'h8000_0000, 32'h8000_0000, 1'b0));
        send_element(pick(KIND_II, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, -1, 0, 1'b1));
        send_element(pick(KIND_CC, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        send_element(pick(KIND_CC, 32'hFFFF_FFFF, 1, 25'h100_0000, 1, 32'h0000_0001,
                          -1, -1, 1'b0));
        send_element(pick(KIND_IC, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
        finish_burst();
        wait_drained();
    endtask

    task automatic test_config_extremes();
        write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        write_reg(3'd7, 32'hDEAD_BEEF);
        for (int i = 0; i < 12; i++)
            send_element(make_element(i[0], i == 11));
        finish_burst();
        wait_drained();
        write_all(0, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 12; i++)
            send_element(make_element(i[0], i == 11));
        finish_burst();
        wait_drained();
    endtask

    task automatic test_random_sweeps(int items);
        int sent, len;
        sent = 0;
        for (int ph = 0; sent < items; ph++) begin
            write_all($urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 1 << 23), $signed($urandom_range(0, 1 << 22)) - (1 << 21),
                      $signed($urandom_range(0, 1 << 22)) - (1 << 21), $urandom_range(0, 1 << 20),
                      $urandom);
            // every fourth phase runs a long stretch with no idling on either side
            idle_on = (ph % 4 != 2);
            for (int k = 0; k < 220 && sent < items; k += len) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
                for (int i = 0; i < len; i++)
                    send_element(make_element($urandom_range(0, 99) < 15, i == len - 1));
                sent += len;
            end
            finish_burst();
            idle_on = 1'b1;
            wait_drained();
        end
    endtask

    task automatic test_drain_pause();
        for (int i = 0; i < 20; i++)
            send_element(make_element(1'b0, i == 19));
        finish_burst();
        wait (expected_updates.size() == 0);
        for (int i = 0; i < 20; i++)
            send_element(make_element(1'b0, i == 19));
        finish_burst();
        wait_drained();
    endtask

    always @(negedge clk)
        pop = (idle_on && $urandom_range(0, 99) < 14) ? 1'b0 : 1'b1;

    always @(posedge clk) begin
        update_t w;
        if (pop && !empty && rst_n) begin
            if (expected_updates.size() == 0) begin
                report_mismatch("unexpected result", 64'd0, 64'd0);
            end else begin
                w = expected_updates.pop_front();
                if (new_coupling !== w.coup)
                    report_mismatch("new_coupling", 64'($unsigned(new_coupling)), 64'(w.coup));
                if (new_momentum !== w.mom)
                    report_mismatch("new_momentum", 64'($unsigned(new_momentum)), 64'(w.mom));
                if (element_counted !== w.counted)
                    report_mismatch("element_counted", 64'(element_counted), 64'(w.counted));
                if (rms_valid !== w.rvalid)
                    report_mismatch("rms_valid", 64'(rms_valid), 64'(w.rvalid));
                if (rms_diff !== w.rms)
                    report_mismatch("rms_diff", 64'(rms_diff), 64'(w.rms));
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge clk) begin
        if ((push && !full) || (pop && !empty))
            stall_cycles = 0;
        else if (++stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        errors = 0;
        stall_cycles = 0;
        idle_on = 1'b1;
        rst_n = 1'b0;
        wr_en = 1'b0; wr_index = '0; wr_data = '0;
        push = 1'b0;
        opcode = '0; pair_freq = '0; pair_expected = '0;
        first_marginal = '0; second_marginal = '0;
        gauge_term = '0; coupling = '0; momentum = '0; last_element = 1'b0;
        step_gain_q = 655; mom_gain_q = 62259; cutoff_q = 0;
        foreach (offset_q[i]) offset_q[i] = 0;
        square_total = 0; tally = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_config_extremes();
        test_drain_pause();
        test_random_sweeps(1650);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/pcmu_pkg.sv
rtl/pcmu_front.sv
rtl/pcmu_engine.sv
rtl/potts_coupling_momentum_update_core.sv
tb/tb_potts_coupling_momentum_update_core.sv
